// File: src/inversion_counter_unit_macros.svh
// Assertion macros for the inversion counter unit.
// ICNT_ASSERT checks a property on the rising edge of clk, ignored while rst is high.
// ICNT_ASSERT_ALWAYS checks a property on every rising edge of clk, reset included.
`ifndef INVERSION_COUNTER_UNIT_MACROS_SVH
`define INVERSION_COUNTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ICNT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ICNT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICNT_ASSERT(label, prop, msg)
`define ICNT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: src/icnt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inversion counter package
// Shared widths, limits and the token control type of the cell chain.
// ----------------------------------------------------------------------------
package icnt_pkg;

  localparam int ICNT_VALUE_W = 32;
  localparam int ICNT_TOTAL_W = 15;
  localparam int ICNT_MAX_LEN = 256;
  localparam logic [ICNT_TOTAL_W-1:0] ICNT_TOTAL_MAX = '1;

  // Control part of a token travelling down the chain.
  typedef struct packed {
    logic valid;
    logic last;
  } icnt_ctrl_t;

endpackage

// File: src/icnt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inversion counter input channel
// Valid/ready channel carrying one list element and its final-element flag.
// ----------------------------------------------------------------------------
interface icnt_in_if
  import icnt_pkg::*;
  ();
  logic                           valid;
  logic                           ready;
  logic signed [ICNT_VALUE_W-1:0] value;
  logic                           last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

// File: src/icnt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inversion counter output channel
// Valid/ready channel carrying the inversion total and overflow flag of a list.
// ----------------------------------------------------------------------------
interface icnt_out_if
  import icnt_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [ICNT_TOTAL_W-1:0] inversions;
  logic                    overflow;

  modport source (output valid, output inversions, output overflow, input ready);
  modport sink (input valid, input inversions, input overflow, output ready);
endinterface

// File: src/icnt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inversion counter cell
// Holds the element at one list position. A passing token of a later position
// is compared against it, and the token of this position writes it.
// ----------------------------------------------------------------------------
module icnt_cell
  import icnt_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 9,
  parameter int CNT_W = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  icnt_ctrl_t                     in_ctrl,
  input  logic signed [ICNT_VALUE_W-1:0] in_value,
  input  logic [IDX_W-1:0]               in_index,
  input  logic [CNT_W-1:0]               in_count,
  output icnt_ctrl_t                     out_ctrl,
  output logic signed [ICNT_VALUE_W-1:0] out_value,
  output logic [IDX_W-1:0]               out_index,
  output logic [CNT_W-1:0]               out_count
);

  logic signed [ICNT_VALUE_W-1:0] stored;
  logic                           greater;
  logic                           own_slot;

  // A token counts this cell only when it comes later in the list.
  assign own_slot = in_ctrl.valid && (in_index == IDX_W'(IDX));
  assign greater  = in_ctrl.valid && (in_index > IDX_W'(IDX)) && (stored > in_value);

  // Token control moves on with every advance of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else if (advance) begin
      out_ctrl <= in_ctrl;
    end
  end

  // Token payload and the held element.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= in_value;
      out_index <= in_index;
      out_count <= in_count + CNT_W'(greater);
      if (own_slot) begin
        stored <= in_value;
      end
    end
  end

endmodule

// File: src/icnt_tally.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inversion counter tally
// Adds the count of each token leaving the chain below the list limit to the
// running total, with saturation, and gives a list's result on its final element.
// ----------------------------------------------------------------------------
`include "inversion_counter_unit_macros.svh"

module icnt_tally
  import icnt_pkg::*;
#(
  parameter int MAX_LEN = ICNT_MAX_LEN,
  parameter int IDX_W   = 9,
  parameter int CNT_W   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  icnt_ctrl_t       tok_ctrl,
  input  logic [IDX_W-1:0] tok_index,
  input  logic [CNT_W-1:0] tok_count,
  output logic             advance,
  icnt_out_if.source       out_stream
);

  logic [ICNT_TOTAL_W-1:0] total;
  logic [ICNT_TOTAL_W-1:0] total_next;
  logic                    truncated;
  logic                    truncated_next;
  logic [ICNT_TOTAL_W:0]   sum;
  logic                    dropped;

  // The chain moves whenever the result register is empty or being taken.
  assign advance = !out_stream.valid || out_stream.ready;

  assign dropped = tok_index == IDX_W'(MAX_LEN);
  assign sum     = {1'b0, total} + (ICNT_TOTAL_W + 1)'(tok_count);

  // Running total update for the token at the end of the chain.
  always_comb begin
    total_next     = total;
    truncated_next = truncated;
    if (dropped) begin
      truncated_next = 1'b1;
    end else if (sum > {1'b0, ICNT_TOTAL_MAX}) begin
      total_next     = ICNT_TOTAL_MAX;
      truncated_next = 1'b1;
    end else begin
      total_next = sum[ICNT_TOTAL_W-1:0];
    end
  end

  // Accumulator state, cleared after the final element of a list.
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      truncated <= 1'b0;
    end else if (advance && tok_ctrl.valid) begin
      if (tok_ctrl.last) begin
        total     <= '0;
        truncated <= 1'b0;
      end else begin
        total     <= total_next;
        truncated <= truncated_next;
      end
    end
  end

  // Result register: one transaction per finished list.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_stream.valid <= 1'b0;
    end else if (advance) begin
      out_stream.valid <= tok_ctrl.valid && tok_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_ctrl.valid && tok_ctrl.last) begin
      out_stream.inversions <= total_next;
      out_stream.overflow   <= truncated_next;
    end
  end

  `ICNT_ASSERT(a_final_clears, advance && tok_ctrl.valid && tok_ctrl.last |=> out_stream.valid && total == '0 && !truncated, "final element did not produce a result and clear the total")
  `ICNT_ASSERT(a_stall_holds, !advance |=> $stable(total) && $stable(truncated), "running total changed while the chain was stalled")

endmodule

// File: src/inversion_counter_unit.sv
`timescale 1ns / 1ps
// Each accepted element walks the registered cells of the chain as a token; the
// tally adds its count to the total and registers a result on a final element.
// Throughput: one element per cycle; the whole cell chain stalls only while a
// result waits in the output register. Reset clears the fill count, the token
// valid bits and the running total; the stored elements are not cleared.
// ----------------------------------------------------------------------------
// Inversion counter unit
// Systolic chain of MAX_LEN cells; each token walks the chain counting the
// greater earlier elements, and a tally stage totals the counts per list.
// ----------------------------------------------------------------------------
`include "inversion_counter_unit_macros.svh"

module inversion_counter_unit
  import icnt_pkg::*;
#(
  parameter int MAX_LEN = ICNT_MAX_LEN
) (
  input  logic      clk,
  input  logic      rst,
  icnt_in_if.sink   in_stream,
  icnt_out_if.source out_stream
);

  localparam int IDX_W = $clog2(MAX_LEN + 1);
  localparam int CNT_W = $clog2(MAX_LEN);

  logic                           advance;
  logic                           accept;
  logic [IDX_W-1:0]               fill_count;
  logic [IDX_W-1:0]               fill_count_next;

  icnt_ctrl_t                     link_ctrl  [0:MAX_LEN];
  logic signed [ICNT_VALUE_W-1:0] link_value [0:MAX_LEN];
  logic [IDX_W-1:0]               link_index [0:MAX_LEN];
  logic [CNT_W-1:0]               link_count [0:MAX_LEN];

  assign in_stream.ready = advance;
  assign accept          = in_stream.valid && in_stream.ready;

  // List position of the next element; saturates at MAX_LEN once full.
  always_comb begin
    fill_count_next = fill_count;
    if (in_stream.last) begin
      fill_count_next = '0;
    end else if (fill_count != IDX_W'(MAX_LEN)) begin
      fill_count_next = fill_count + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // Token entering the first cell.
  assign link_ctrl[0].valid = in_stream.valid;
  assign link_ctrl[0].last  = in_stream.last;
  assign link_value[0]      = in_stream.value;
  assign link_index[0]      = fill_count;
  assign link_count[0]      = '0;

  // The cell chain.
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    icnt_cell #(
      .IDX   (k),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_ctrl   (link_ctrl[k]),
      .in_value  (link_value[k]),
      .in_index  (link_index[k]),
      .in_count  (link_count[k]),
      .out_ctrl  (link_ctrl[k+1]),
      .out_value (link_value[k+1]),
      .out_index (link_index[k+1]),
      .out_count (link_count[k+1])
    );
  end

  // Running total and result register.
  icnt_tally #(
    .MAX_LEN (MAX_LEN),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_tally (
    .clk        (clk),
    .rst        (rst),
    .tok_ctrl   (link_ctrl[MAX_LEN]),
    .tok_index  (link_index[MAX_LEN]),
    .tok_count  (link_count[MAX_LEN]),
    .advance    (advance),
    .out_stream (out_stream)
  );

  `ICNT_ASSERT_ALWAYS(a_fill_bounded, rst || (fill_count <= IDX_W'(MAX_LEN)), "fill count passed the list limit")
  `ICNT_ASSERT(a_last_restarts, accept && in_stream.last |=> fill_count == '0, "final element did not restart the list position")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inversion counter unit testbench
// Streams directed and random lists of signed elements into the unit, counts
// the inversions of each list in a behavioural predictor and compares every
// result transaction, in order, with the expected total and overflow flag.
// The sender works in bursts with random gaps and the receiver stalls on
// patterns of its own, including one long hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb;
  import icnt_pkg::*;

  localparam int LIST_CAP     = ICNT_MAX_LEN;
  localparam int DIRECTED_N   = 23;
  localparam int RANDOM_ITEMS = 1830;
  localparam int DRAIN_CYCLES = 2 * (LIST_CAP + 1);
  localparam int HOLD_CYCLES  = 1000;
  localparam int HOLD_AT      = DIRECTED_N + 60;
  localparam int IDLE_LIMIT   = 4000;

  typedef struct packed {
    logic [ICNT_TOTAL_W-1:0] inversions;
    logic                    overflow;
  } list_result_t;

  // One element to send; typed rows carry a result read straight off the list.
  typedef struct packed {
    logic [ICNT_VALUE_W-1:0] value;
    logic                    last;
    logic                    typed;
    list_result_t            result;
  } element_t;

  typedef enum {
    SINK_FREE,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  icnt_in_if  in_bus ();
  icnt_out_if out_bus ();

  inversion_counter_unit #(
    .MAX_LEN(LIST_CAP)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_bus),
    .out_stream(out_bus)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed lists: single element, extremes, sign boundary, equal values,
  // a fully descending run and two lists left to the predictor.
  element_t directed_rows [DIRECTED_N] = '{
    '{32'h0000_0000, 1'b1, 1'b1, '{15'd0, 1'b0}},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b1, 1'b1, '{15'd1, 1'b0}},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{15'd0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b1, 1'b1, '{15'd0, 1'b0}},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{15'd1, 1'b0}},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b1, 1'b1, '{15'd0, 1'b0}},
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b1, 1'b1, '{15'd6, 1'b0}},
    '{32'h0000_0007, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFD, 1'b0, 1'b0, '0},
    '{32'h0000_0007, 1'b0, 1'b0, '0},
    '{32'h0000_0064, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFD, 1'b1, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, '0}
  };

  element_t     stim_q [$];
  list_result_t pending_totals [$];

  // Predictor state for the list currently being counted.
  logic signed [ICNT_VALUE_W-1:0] kept_vals [LIST_CAP];
  int unsigned kept_cnt    = 0;
  int unsigned pair_total  = 0;
  bit          clipped     = 1'b0;

  int unsigned n_taken       = 0;
  int unsigned lists_seen    = 0;
  int unsigned clipped_lists = 0;
  int unsigned results_done  = 0;
  int unsigned peak_total    = 0;
  int unsigned idle_cycles   = 0;
  int          mismatches    = 0;
  bit          started       = 1'b0;

  // Folds one element into the running count. Returns 1 with the list's
  // result when the element closes the list, and then clears for the next.
  function automatic bit fold_element(input logic signed [ICNT_VALUE_W-1:0] v,
                                      input logic fin, output list_result_t res);
    int unsigned greater;
    int k;
    greater = 0;
    res = '0;
    if (kept_cnt < LIST_CAP) begin
      for (k = 0; k < kept_cnt; k++) begin
        if (kept_vals[k] > v) greater++;
      end
      if (pair_total + greater > ICNT_TOTAL_MAX) begin
        pair_total = 32'(ICNT_TOTAL_MAX);
        clipped = 1'b1;
      end else begin
        pair_total += greater;
      end
      kept_vals[kept_cnt] = v;
      kept_cnt++;
    end else begin
      // The list is full: the element is dropped and only marks truncation.
      clipped = 1'b1;
    end
    if (!fin) return 1'b0;
    res.inversions = pair_total[ICNT_TOTAL_W-1:0];
    res.overflow = clipped;
    kept_cnt = 0;
    pair_total = 0;
    clipped = 1'b0;
    return 1'b1;
  endfunction

  // Monitor: predict on every input transaction, check every output one.
  always @(posedge clk) begin
    list_result_t folded;
    list_result_t want;
    element_t     item;
    if (!rst) begin
      if (in_bus.valid && in_bus.ready) begin
        item = stim_q[n_taken];
        if (fold_element(in_bus.value, in_bus.last, folded)) begin
          pending_totals.insert(pending_totals.size(), item.typed ? item.result : folded);
          lists_seen++;
          if (folded.overflow) clipped_lists++;
        end
        n_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_totals.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual inversions=%0d overflow=%0b",
                   $time, out_bus.inversions, out_bus.overflow);
          mismatches++;
        end else begin
          want = pending_totals.pop_front();
          if (out_bus.inversions !== want.inversions) begin
            $display("%0t: inversions mismatch, expected %0d, actual %0d",
                     $time, want.inversions, out_bus.inversions);
            mismatches++;
          end
          if (out_bus.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %0b, actual %0b",
                     $time, want.overflow, out_bus.overflow);
            mismatches++;
          end
          results_done++;
          if (want.inversions > peak_total) peak_total = 32'(want.inversions);
        end
      end
    end
  end

  // Watchdog: give up when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps; an offered
  // element is held until the unit takes it.
  initial begin
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned offered;
    burst_left = 0;
    gap_left = 0;
    offered = 0;
    in_bus.valid = 1'b0;
    in_bus.value = '0;
    in_bus.last = 1'b0;
    wait (started);
    forever begin
      @(negedge clk);
      if (n_taken == stim_q.size()) break;
      if (!(in_bus.valid && offered == n_taken)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid = 1'b0;
        end else begin
          burst_left--;
          offered = n_taken;
          in_bus.valid = 1'b1;
          in_bus.value = stim_q[n_taken].value;
          in_bus.last = stim_q[n_taken].last;
        end
      end
    end
    in_bus.valid = 1'b0;
  end

  // Receiver: switches between stall modes, and once holds off for a long
  // stretch so that a result waits and the unit stalls its input.
  initial begin
    sink_mode_e  mode;
    int unsigned mode_left;
    logic [7:0]  stall_pat;
    bit          held_off;
    mode = SINK_FREE;
    mode_left = 0;
    stall_pat = 8'hFF;
    held_off = 1'b0;
    out_bus.ready = 1'b0;
    wait (started);
    forever begin
      @(negedge clk);
      if (!held_off && n_taken >= HOLD_AT) begin
        held_off = 1'b1;
        out_bus.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
          stall_pat = 8'($urandom) | 8'h01;
        end
        mode_left--;
        case (mode)
          SINK_FREE: begin
            out_bus.ready = 1'b1;
          end
          SINK_RANDOM: begin
            out_bus.ready = ($urandom_range(0, 9) < 7);
          end
          SINK_PATTERN: begin
            out_bus.ready = stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[7:1]};
          end
          default: begin
            out_bus.ready = ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Main sequence: build the stimulus, reset, then wait for every result.
  initial begin
    element_t    item;
    int unsigned list_no;
    int unsigned len;
    int unsigned k;
    foreach (directed_rows[i]) stim_q.insert(stim_q.size(), directed_rows[i]);

    // Random lists: mostly short ones, with a full descending list, lists
    // that run past the capacity and a list that fills it exactly.
    list_no = 0;
    while (stim_q.size() < DIRECTED_N + RANDOM_ITEMS) begin
      if (list_no == 8 || list_no == 45) len = LIST_CAP;
      else if (list_no == 25) len = LIST_CAP + $urandom_range(1, 40);
      else if (list_no == 65) len = LIST_CAP + 1;
      else len = $urandom_range(1, 16);
      for (k = 0; k < len; k++) begin
        item = '0;
        item.last = (k == len - 1);
        if (list_no == 8) begin
          item.value = 1000 - 7 * k;
        end else begin
          case ($urandom_range(0, 2))
            0: item.value = $urandom;
            1: item.value = $urandom_range(0, 8) - 4;
            default: item.value = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                       : 32'h8000_0000 + $urandom_range(0, 3);
          endcase
        end
        stim_q.insert(stim_q.size(), item);
      end
      list_no++;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    started = 1'b1;

    wait (n_taken == stim_q.size());
    wait (pending_totals.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d elements in %0d lists, %0d of them truncated past the capacity.",
             n_taken, lists_seen, clipped_lists);
    $display("Checked %0d results; largest inversion total seen was %0d.",
             results_done, peak_total);
    if (mismatches == 0 && pending_totals.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
